>>> rtl/fna_pkg.sv
package fna_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int CROSS_BITS = PROD_BITS + 2;
    localparam int NORM_BITS  = 16;
    localparam int AREA_BITS  = 51;
    localparam int LIM_BITS   = 20;
    localparam int MAG_BITS   = 62;
    localparam int SQ_BITS    = 2 * MAG_BITS + 2;
    localparam int ROOT_BITS  = 63;
    localparam int DIV_BITS   = MAG_BITS + 15;
    localparam int QUO_BITS   = 16;

    localparam logic [15:0] NORM_ONE = 16'd16384;

    localparam int IN_BITS  = 3 * COORD_BITS;
    localparam int IN_BYTES = (IN_BITS + 7) / 8;
    localparam int OUT_BITS = 3 * NORM_BITS + AREA_BITS;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    typedef struct packed {
        logic [NORM_BITS-1:0] nx;
        logic [NORM_BITS-1:0] ny;
        logic [NORM_BITS-1:0] nz;
        logic [AREA_BITS-1:0] area;
        logic                 degenerate;
        logic                 bad_count;
    } result_t;

endpackage

>>> rtl/fna_core.sv
// Face arithmetic sequencer: cross products, one shared square-root step,
// one shared divide step. Starts on start, pulses done with result.
module fna_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [2:0]                      count,
    input  logic [fna_pkg::LIM_BITS-1:0]    limit,
    input  logic signed [fna_pkg::COORD_BITS-1:0] vtx [12],
    output logic                            busy,
    output logic                            done,
    output fna_pkg::result_t                result
);
    localparam int CB = fna_pkg::CROSS_BITS;
    localparam int DB = fna_pkg::DIFF_BITS;
    localparam int SB = fna_pkg::SQ_BITS;
    localparam int MB = fna_pkg::MAG_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIFF  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_VSEL  = 4'd3;
    localparam logic [3:0] S_SHIFT = 4'd4;
    localparam logic [3:0] S_SQ    = 4'd5;
    localparam logic [3:0] S_ROOT  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] state_reg;
    logic [6:0] step_reg;
    logic [1:0] vec_reg;   // 0 n1, 1 n2, 2 sum
    logic quad_reg;

    logic signed [DB-1:0] d_reg [9];
    logic signed [CB-1:0] c_reg [9];   // n1, n2, sum
    logic [CB-1:0] a_reg [3];
    logic [2:0]    neg_reg;
    logic          big_reg;
    logic [SB-1:0] s_reg;
    logic [SB-1:0] rem_reg;
    logic [fna_pkg::ROOT_BITS-1:0] root_reg;
    logic [fna_pkg::ROOT_BITS-1:0] l1_reg;
    logic [fna_pkg::ROOT_BITS-1:0] l2_reg;
    logic [fna_pkg::DIV_BITS-1:0]  dn_reg;
    logic [63:0] drem_reg;
    logic [fna_pkg::QUO_BITS-1:0]  q_reg;
    logic [1:0]    comp_reg;
    fna_pkg::result_t res_reg;

    // shared cross-product multiplier operands, 25x25 signed
    logic signed [DB-1:0]   ma, mb;
    logic signed [2*DB-1:0] mp;
    assign mp = ma * mb;

    logic [3:0] mul_i;
    always_comb begin
        ma = '0;
        mb = '0;
        unique case (mul_i)
            4'd0: begin ma = d_reg[1]; mb = d_reg[5]; end
            4'd1: begin ma = d_reg[2]; mb = d_reg[4]; end
            4'd2: begin ma = d_reg[2]; mb = d_reg[3]; end
            4'd3: begin ma = d_reg[0]; mb = d_reg[5]; end
            4'd4: begin ma = d_reg[0]; mb = d_reg[4]; end
            4'd5: begin ma = d_reg[1]; mb = d_reg[3]; end
            4'd6: begin ma = d_reg[4]; mb = d_reg[8]; end
            4'd7: begin ma = d_reg[5]; mb = d_reg[7]; end
            4'd8: begin ma = d_reg[5]; mb = d_reg[6]; end
            4'd9: begin ma = d_reg[3]; mb = d_reg[8]; end
            4'd10: begin ma = d_reg[3]; mb = d_reg[7]; end
            4'd11: begin ma = d_reg[4]; mb = d_reg[6]; end
            default: begin ma = '0; mb = '0; end
        endcase
    end
    assign mul_i = step_reg[3:0];

    // square step: magnitudes in 31-bit halves, one partial product a cycle
    logic [MB-1:0] sq_mag;
    logic [30:0] sqa, sqb;
    logic [61:0] sqp;
    logic [1:0]  sq_c;
    logic [1:0]  sq_h;
    assign sq_c   = step_reg[3:2];
    assign sq_h   = step_reg[1:0];
    assign sq_mag = MB'(a_reg[sq_c]);
    always_comb begin
        sqa = (sq_h[1]) ? sq_mag[61:31] : sq_mag[30:0];
        sqb = (sq_h[0]) ? sq_mag[61:31] : sq_mag[30:0];
    end
    assign sqp = sqa * sqb;
    logic [6:0] sq_sh;
    assign sq_sh = 7'(({1'b0, sq_h[1]} + {1'b0, sq_h[0]}) * 31);

    // square root, restoring, two radicand bits consumed per pass
    logic [SB+1:0] rt_trial;
    logic [SB-1:0] rt_rem;
    logic [SB-1:0] rt_pair;
    logic [6:0]    rt_bit;
    logic          rt_ge;
    logic [fna_pkg::ROOT_BITS-1:0] root_next;
    assign rt_bit  = 7'(fna_pkg::ROOT_BITS - 1) - step_reg;
    assign rt_pair = (s_reg >> {rt_bit, 1'b0}) & SB'(3);
    assign rt_rem  = (rem_reg << 2) | rt_pair;
    assign rt_trial = {2'b00, SB'({root_reg, 2'b01})};
    assign rt_ge   = ({2'b00, rt_rem} >= rt_trial);
    assign root_next = {root_reg[fna_pkg::ROOT_BITS-2:0], rt_ge};

    // divide step
    logic [64:0] dv_rem;
    logic        dv_ge;
    assign dv_rem = {drem_reg, dn_reg[fna_pkg::DIV_BITS-1]};
    assign dv_ge  = (dv_rem >= {2'b00, root_reg});

    logic [fna_pkg::ROOT_BITS:0] area_sum;
    assign area_sum = {1'b0, l1_reg} + {1'b0, l2_reg};

    logic [CB-1:0] abs_c [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            abs_c[i] = c_reg[vec_reg * 3 + i][CB-1] ? CB'(-c_reg[vec_reg * 3 + i])
                                                     : CB'(c_reg[vec_reg * 3 + i]);
        end
    end

    // final quotient bit folded in before rounding
    logic [fna_pkg::QUO_BITS-1:0] q_full;
    logic [fna_pkg::QUO_BITS:0] q_rnd;
    logic [fna_pkg::NORM_BITS-1:0] q_cap;
    assign q_full = {q_reg[14:0], dv_ge};
    assign q_rnd = ({1'b0, q_full} + 17'd1) >> 1;
    assign q_cap = (q_rnd > 17'(fna_pkg::NORM_ONE)) ? fna_pkg::NORM_ONE : q_rnd[15:0];

    logic [fna_pkg::NORM_BITS-1:0] comp_out;
    assign comp_out = neg_reg[comp_reg] ? 16'(-q_cap) : q_cap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        quad_reg <= (count == 3'd4);
                        if (count != 3'd3 && count != 3'd4) begin
                            res_reg <= '{nx: '0, ny: '0, nz: '0, area: '0,
                                         degenerate: 1'b0, bad_count: 1'b1};
                            state_reg <= S_DONE;
                        end else begin
                            res_reg   <= '0;
                            state_reg <= S_DIFF;
                        end
                    end
                end
                S_DIFF: begin
                    for (int i = 0; i < 9; i++) begin
                        d_reg[i] <= DB'(vtx[i + 3]) - DB'(vtx[i % 3]);
                    end
                    for (int i = 0; i < 9; i++) c_reg[i] <= '0;
                    step_reg  <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    // even index adds, odd subtracts into component
                    if (mul_i[0])
                        c_reg[mul_i >> 1] <= c_reg[mul_i >> 1] - CB'(mp);
                    else
                        c_reg[mul_i >> 1] <= c_reg[mul_i >> 1] + CB'(mp);
                    if (step_reg == 7'd11 || (!quad_reg && step_reg == 7'd5)) begin
                        vec_reg   <= '0;
                        state_reg <= S_VSEL;
                    end else begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                S_VSEL: begin
                    if (vec_reg == 2'd0) begin
                        for (int i = 0; i < 3; i++)
                            c_reg[6 + i] <= c_reg[i] + (quad_reg ? c_reg[3 + i] : '0);
                    end
                    for (int i = 0; i < 3; i++) begin
                        a_reg[i]   <= abs_c[i];
                        neg_reg[i] <= c_reg[vec_reg * 3 + i][CB-1];
                    end
                    big_reg   <= 1'b0;
                    state_reg <= S_SHIFT;
                end
                S_SHIFT: begin
                    if ((a_reg[0] >> MB) != '0 || (a_reg[1] >> MB) != '0 ||
                        (a_reg[2] >> MB) != '0) begin
                        for (int i = 0; i < 3; i++) a_reg[i] <= a_reg[i] >> 1;
                        big_reg <= 1'b1;
                    end else begin
                        s_reg     <= '0;
                        step_reg  <= '0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ: begin
                    s_reg <= s_reg + (SB'(sqp) << sq_sh);
                    if (step_reg == 7'd11) begin
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= S_ROOT;
                    end else begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                S_ROOT: begin
                    if (rt_ge)
                        rem_reg <= rt_rem - SB'(rt_trial);
                    else
                        rem_reg <= rt_rem;
                    root_reg <= root_next;
                    if (step_reg == 7'(fna_pkg::ROOT_BITS - 1)) begin
                        step_reg <= '0;
                        unique case (vec_reg)
                            2'd0: begin
                                // length of n1; a triangle skips n2
                                l1_reg <= big_reg ? ((fna_pkg::ROOT_BITS)'(1) << MB)
                                                  : root_next;
                                if (quad_reg) begin
                                    vec_reg <= 2'd1;
                                end else begin
                                    vec_reg <= 2'd2;
                                    l2_reg  <= '0;
                                end
                                state_reg <= S_VSEL;
                            end
                            2'd1: begin
                                l2_reg <= big_reg ? ((fna_pkg::ROOT_BITS)'(1) << MB)
                                                  : root_next;
                                vec_reg   <= 2'd2;
                                state_reg <= S_VSEL;
                            end
                            default: begin
                                // summed normal: degenerate check, area, first divide unless degenerate
                                if (!big_reg &&
                                    root_next <= (fna_pkg::ROOT_BITS)'(limit)) begin
                                    res_reg.degenerate <= 1'b1;
                                    state_reg <= S_DONE;
                                end else begin
                                    comp_reg  <= '0;
                                    state_reg <= S_DIV;
                                end
                                res_reg.area <= (area_sum[fna_pkg::ROOT_BITS:1] >
                                    (fna_pkg::ROOT_BITS)'({fna_pkg::AREA_BITS{1'b1}}))
                                    ? '1 : fna_pkg::AREA_BITS'(area_sum >> 1);
                                dn_reg   <= fna_pkg::DIV_BITS'(a_reg[0]) << 15;
                                drem_reg <= '0;
                                q_reg    <= '0;
                            end
                        endcase
                    end else begin
                        step_reg <= step_reg + 7'd1;
                    end
                end
                S_DIV: begin
                    // restoring divide by length, one quotient bit a cycle
                    if (step_reg == 7'(fna_pkg::DIV_BITS - 1)) begin
                        step_reg <= '0;
                        drem_reg <= '0;
                        q_reg    <= '0;
                        unique case (comp_reg)
                            2'd0: begin
                                res_reg.nx <= comp_out;
                                dn_reg     <= fna_pkg::DIV_BITS'(a_reg[1]) << 15;
                                comp_reg   <= 2'd1;
                            end
                            2'd1: begin
                                res_reg.ny <= comp_out;
                                dn_reg     <= fna_pkg::DIV_BITS'(a_reg[2]) << 15;
                                comp_reg   <= 2'd2;
                            end
                            default: begin
                                res_reg.nz <= comp_out;
                                state_reg  <= S_DONE;
                            end
                        endcase
                    end else begin
                        if (dv_ge)
                            drem_reg <= 64'(dv_rem - {2'b00, root_reg});
                        else
                            drem_reg <= dv_rem[63:0];
                        q_reg    <= q_full;
                        dn_reg   <= dn_reg << 1;
                        step_reg <= step_reg + 7'd1;
                    end
                end
                S_DONE: begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_DONE);
    assign result = res_reg;

`ifndef SYNTHESIS
    a_done_one: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done) else $error("done held");
    a_bad_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        done && res_reg.bad_count |-> res_reg.area == '0 && !res_reg.degenerate)
        else $error("bad count result not clear");
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        done && res_reg.degenerate |-> res_reg.nx == '0 && res_reg.nz == '0)
        else $error("degenerate normal not zero");
`endif
endmodule

>>> rtl/face_normal_and_area.sv
// Face normal and area.
// The tlast vertex starts the shared sequencer.
// m_tvalid rises once the result is done; a quad adds a vector length over a triangle,
// a degenerate face skips the divides and a bad count skips all arithmetic.
// One face at a time; the next face loads while a result waits, its start held until then.
// Synchronous active-low reset clears count, limit and control; store is not cleared.
module face_normal_and_area (
    input  logic aclk,
    input  logic aresetn,
    input  logic                              cfg_we,
    input  logic [fna_pkg::LIM_BITS-1:0]      cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // coord_x, coord_y, coord_z
    input  logic [8*fna_pkg::IN_BYTES-1:0]    s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // normal_x, normal_y, normal_z, face_area, pad
    output logic [8*fna_pkg::OUT_BYTES-1:0]   m_tdata,
    // degenerate, bad_count
    output logic [1:0]                        m_tuser
);
    localparam int CW = fna_pkg::COORD_BITS;

    logic [fna_pkg::LIM_BITS-1:0] limit_reg;
    logic [2:0] count_reg;
    logic signed [CW-1:0] vtx_reg [12];
    logic start_reg;
    logic [2:0] fcount_reg;
    logic out_valid_reg;
    fna_pkg::result_t out_reg;
    logic busy, done;
    logic core_start;
    logic [3:0] vbase;
    fna_pkg::result_t res;

    assign s_tready   = !busy && !start_reg;
    assign core_start = start_reg && !out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= '0;
            count_reg     <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) limit_reg <= cfg_wdata;
            if (core_start)
                start_reg <= 1'b0;
            else if (s_tvalid && s_tready && s_tlast)
                start_reg <= 1'b1;
            if (s_tvalid && s_tready) begin
                if (s_tlast) begin
                    count_reg  <= '0;
                    fcount_reg <= (count_reg != 3'd7) ? count_reg + 3'd1 : count_reg;
                end else if (count_reg != 3'd7) begin
                    count_reg <= count_reg + 3'd1;
                end
            end
            if (done) begin
                out_valid_reg <= 1'b1;
                out_reg       <= res;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // vertex store, first four vertices
    assign vbase = {2'b00, count_reg[1:0]} * 4'd3;
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready && count_reg < 3'd4) begin
            vtx_reg[vbase]        <= s_tdata[CW-1:0];
            vtx_reg[vbase + 4'd1] <= s_tdata[2*CW-1:CW];
            vtx_reg[vbase + 4'd2] <= s_tdata[3*CW-1:2*CW];
        end
    end

    fna_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (core_start),
        .count   (fcount_reg),
        .limit   (limit_reg),
        .vtx     (vtx_reg),
        .busy    (busy),
        .done    (done),
        .result  (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = (8*fna_pkg::OUT_BYTES)'({out_reg.area, out_reg.nz,
                                               out_reg.ny, out_reg.nx});
    assign m_tuser  = {out_reg.bad_count, out_reg.degenerate};

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_tready) else $error("accept while busy");
    a_start_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        core_start |=> !core_start) else $error("start held");
    a_done_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !out_valid_reg) else $error("result overwritten");
`endif
endmodule

>>> dv/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [2:0][127:0] vec3_t;

    // Face predictor and store of expected face results
    class face_board;
        logic signed [63:0] vstore [12];
        int unsigned        vcount;
        logic [19:0]        limit;
        fna_pkg::result_t   pending [$];
        int                 errors;

        function new();
            vcount = 0;
            limit  = '0;
            errors = 0;
        endfunction

        function vec3_t cross3(vec3_t u, vec3_t v);
            vec3_t o;
            o[0] = $signed(u[1]) * $signed(v[2]) - $signed(u[2]) * $signed(v[1]);
            o[1] = $signed(u[2]) * $signed(v[0]) - $signed(u[0]) * $signed(v[2]);
            o[2] = $signed(u[0]) * $signed(v[1]) - $signed(u[1]) * $signed(v[0]);
            return o;
        endfunction

        function logic [63:0] int_sqrt(logic [127:0] s);
            logic [63:0] r;
            logic [63:0] t;
            r = '0;
            for (int b = 63; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if ({64'd0, t} * {64'd0, t} <= s) r = t;
            end
            return r;
        endfunction

        // length of a vector; magnitudes pre-shifted below 2^62 when huge
        function logic [63:0] vec_len(vec3_t c, output vec3_t mag, output logic [2:0] neg,
                                      output int shift);
            logic [127:0] s;
            bit big;
            shift = 0;
            for (int i = 0; i < 3; i++) begin
                neg[i] = c[i][127];
                mag[i] = neg[i] ? -c[i] : c[i];
            end
            big = 1;
            while (big) begin
                big = 0;
                for (int i = 0; i < 3; i++) if (mag[i] >= (128'd1 << 62)) big = 1;
                if (big) begin
                    for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
                    shift++;
                end
            end
            s = '0;
            for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
            return int_sqrt(s);
        endfunction

        function logic [63:0] capped_len(vec3_t c);
            vec3_t mg;
            logic [2:0] ng;
            int k;
            logic [63:0] l;
            l = vec_len(c, mg, ng, k);
            return (k != 0) ? (64'd1 << 62) : l;
        endfunction

        function fna_pkg::result_t face_result();
            fna_pkg::result_t r;
            vec3_t d1, d2, d3, n1, n2, sum, am;
            logic [2:0] ng;
            int k;
            logic [63:0] m2, len;
            logic [64:0] area;
            logic [127:0] q;
            r = '0;
            if (vcount != 3 && vcount != 4) begin
                r.bad_count = 1'b1;
                return r;
            end
            for (int i = 0; i < 3; i++) begin
                d1[i] = 128'($signed(vstore[3+i] - vstore[i]));
                d2[i] = 128'($signed(vstore[6+i] - vstore[i]));
                d3[i] = 128'($signed(vstore[9+i] - vstore[i]));
            end
            n1 = cross3(d1, d2);
            sum = n1;
            m2 = '0;
            if (vcount == 4) begin
                n2 = cross3(d2, d3);
                for (int i = 0; i < 3; i++) sum[i] = n1[i] + n2[i];
                m2 = capped_len(n2);
            end
            area = ({1'b0, capped_len(n1)} + {1'b0, m2}) >> 1;
            r.area = (area > 65'((64'd1 << 51) - 1)) ? {fna_pkg::AREA_BITS{1'b1}}
                                                      : area[50:0];
            len = vec_len(sum, am, ng, k);
            if (k == 0 && len <= {44'd0, limit}) begin
                r.degenerate = 1'b1;
                return r;
            end
            for (int i = 0; i < 3; i++) begin
                q = ((am[i] << 15) / {64'd0, len} + 1) >> 1;
                if (q > 128'(fna_pkg::NORM_ONE)) q = 128'(fna_pkg::NORM_ONE);
                q = ng[i] ? -q : q;
                case (i)
                    0: r.nx = q[15:0];
                    1: r.ny = q[15:0];
                    default: r.nz = q[15:0];
                endcase
            end
            return r;
        endfunction

        function void note_vertex(logic [23:0] x, logic [23:0] y, logic [23:0] z, bit last);
            if (vcount < 4) begin
                vstore[vcount*3]   = 64'($signed(x));
                vstore[vcount*3+1] = 64'($signed(y));
                vstore[vcount*3+2] = 64'($signed(z));
            end
            if (vcount < 7) vcount++;
            if (last) begin
                pending.insert(pending.size(), face_result());
                vcount = 0;
            end
        endfunction

        function void check_result(logic [103:0] data, logic [1:0] user);
            fna_pkg::result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tuser=%b", $time, data, user);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[15:0] !== e.nx) begin
                $display("%0t: normal_x exp %0d got %0d", $time, $signed(e.nx),
                         $signed(data[15:0]));
                errors++;
            end
            if (data[31:16] !== e.ny) begin
                $display("%0t: normal_y exp %0d got %0d", $time, $signed(e.ny),
                         $signed(data[31:16]));
                errors++;
            end
            if (data[47:32] !== e.nz) begin
                $display("%0t: normal_z exp %0d got %0d", $time, $signed(e.nz),
                         $signed(data[47:32]));
                errors++;
            end
            if (data[98:48] !== e.area) begin
                $display("%0t: face_area exp %0d got %0d", $time, e.area, data[98:48]);
                errors++;
            end
            if (user[0] !== e.degenerate) begin
                $display("%0t: degenerate exp %b got %b", $time, e.degenerate, user[0]);
                errors++;
            end
            if (user[1] !== e.bad_count) begin
                $display("%0t: bad_count exp %b got %b", $time, e.bad_count, user[1]);
                errors++;
            end
        endfunction
    endclass

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_we;
    logic [fna_pkg::LIM_BITS-1:0] cfg_wdata;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [71:0]                  s_tdata;
    logic                         s_tlast;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [103:0]                 m_tdata;
    logic [1:0]                   m_tuser;

    face_board board;
    int        vertex_total;
    bit        no_idle;

    face_normal_and_area u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 13);
    endfunction

    // one vertex transfer; valid stays high when the next gap is zero
    task automatic send_vertex(logic [23:0] x, logic [23:0] y, logic [23:0] z, bit last);
        int gap;
        bit rdy;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tlast  <= last;
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        board.note_vertex(x, y, z, last);
        vertex_total++;
    endtask

    function automatic logic [23:0] rand_coord(int mode);
        case (mode)
            0: return 24'($urandom());
            1: return 24'($signed($urandom_range(0, 8)) - 4);
            2: return 24'($signed($urandom_range(0, 8191)) - 4096);
            default: return $urandom_range(0, 1) ? 24'h7FFFFF - 24'($urandom_range(0, 3))
                                                 : 24'h800000 + 24'($urandom_range(0, 3));
        endcase
    endfunction

    // random face of n vertices; collinear faces now and then
    task automatic send_face(int n, int mode);
        logic [23:0] ax, ay, az, bx, by, bz;
        bit line;
        line = ($urandom_range(0, 9) == 0);
        ax = rand_coord(mode); ay = rand_coord(mode); az = rand_coord(mode);
        bx = rand_coord(2);    by = rand_coord(2);    bz = rand_coord(2);
        for (int i = 0; i < n; i++) begin
            if (line && i > 0)
                send_vertex(ax + 24'(i) * bx, ay + 24'(i) * by, az + 24'(i) * bz, i == n - 1);
            else if (i == 0)
                send_vertex(ax, ay, az, n == 1);
            else
                send_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode), i == n - 1);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_limit(logic [19:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        board.limit = v;
    endtask

    // result side: random stalls, check each transfer
    initial begin
        int gap;
        bit got;
        logic [103:0] d;
        logic [1:0] u;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                got = m_tvalid;
                d = m_tdata;
                u = m_tuser;
                @(posedge aclk);
            end while (!got);
            board.check_result(d, u);
        end
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int n;
        logic [19:0] lim;
        board = new();
        vertex_total = 0;
        no_idle = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: plain triangle and quad, extremes, collapsed faces, bad counts
        send_vertex(24'd0, 24'd0, 24'd0, 0);
        send_vertex(24'd4096, 24'd0, 24'd0, 0);
        send_vertex(24'd0, 24'd4096, 24'd0, 1);
        send_vertex(24'd0, 24'd0, 24'd0, 0);
        send_vertex(24'd4096, 24'd0, 24'd0, 0);
        send_vertex(24'd4096, 24'd4096, 24'd0, 0);
        send_vertex(24'd0, 24'd4096, 24'd0, 1);
        send_vertex(24'h800000, 24'h800000, 24'h800000, 0);
        send_vertex(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 0);
        send_vertex(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 0);
        send_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 1);
        send_vertex(24'd5, 24'd5, 24'd5, 0);
        send_vertex(24'd5, 24'd5, 24'd5, 0);
        send_vertex(24'd5, 24'd5, 24'd5, 1);
        send_vertex(24'd7, 24'd1, 24'd2, 1);
        send_vertex(24'd1, 24'd2, 24'd3, 0);
        send_vertex(24'd9, 24'd8, 24'd7, 1);
        for (int i = 0; i < 6; i++)
            send_vertex(24'($urandom()), 24'($urandom()), 24'($urandom()), i == 5);
        write_limit(20'hFFFFF);
        send_face(3, 2);

        // random phases over several limit settings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: lim = '0;
                1: lim = 20'hFFFFF;
                2: lim = 20'($urandom());
                default: lim = 20'($urandom_range(0, 15));
            endcase
            write_limit(lim);
            no_idle = (ph == 2);
            while (vertex_total < 25 + (ph + 1) * 137) begin
                if ($urandom_range(0, 99) < 85) n = $urandom_range(3, 4);
                else n = $urandom_range(1, 9);
                send_face(n, $urandom_range(0, 3));
            end
        end
        no_idle = 0;

        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
